[rtl/m3i_pkg.sv]
// ----------------------------------------------------------------------------
// m3i_pkg
// Shared constants for the 3x3 matrix inverse unit: element count and the
// operand table of the nine cofactors.
// ----------------------------------------------------------------------------
package m3i_pkg;

  // number of matrix elements, row-major a00..a22
  localparam int NUM_EL = 9;

  // cofactor k = a[p]*a[q] - a[s]*a[t], stored as {p, q, s, t}
  localparam int COF_IDX [NUM_EL][4] = '{
    '{4, 8, 5, 7},
    '{2, 7, 1, 8},
    '{1, 5, 2, 4},
    '{5, 6, 3, 8},
    '{0, 8, 2, 6},
    '{2, 3, 0, 5},
    '{3, 7, 4, 6},
    '{1, 6, 0, 7},
    '{0, 4, 1, 3}
  };

endpackage

[rtl/m3i_fifo.sv]
// ----------------------------------------------------------------------------
// m3i_fifo
// Small register queue with full and empty flags decoded from a registered
// fill count. DEPTH must be a power of two.
// ----------------------------------------------------------------------------
module m3i_fifo #(
  parameter int DATA_BITS = 32,
  parameter int DEPTH     = 4
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 push_i,
  input  logic [DATA_BITS-1:0] data_i,
  output logic                 full_o,
  input  logic                 pop_i,
  output logic [DATA_BITS-1:0] data_o,
  output logic                 empty_o
);

  localparam int AW = $clog2(DEPTH);

  logic [DATA_BITS-1:0] mem_q [DEPTH];
  logic [AW-1:0]        wr_q, rd_q;
  logic [AW:0]          cnt_q;
  logic                 push_ok, pop_ok;

  assign full_o  = (cnt_q == (AW+1)'(DEPTH));
  assign empty_o = (cnt_q == '0);
  assign push_ok = push_i && !full_o;
  assign pop_ok  = pop_i && !empty_o;
  assign data_o  = mem_q[rd_q];

  // pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      if (push_ok) wr_q <= wr_q + 1'b1;
      if (pop_ok)  rd_q <= rd_q + 1'b1;
      if (push_ok && !pop_ok)      cnt_q <= cnt_q + 1'b1;
      else if (pop_ok && !push_ok) cnt_q <= cnt_q - 1'b1;
    end
  end

  // entry storage
  always_ff @(posedge clk_i) begin
    if (push_ok) mem_q[wr_q] <= data_i;
  end

endmodule

[rtl/m3i_front.sv]
// ----------------------------------------------------------------------------
// m3i_front
// Front pipeline: registers the matrix, forms the nine cofactors and the
// determinant by first-row expansion, all exact in two's complement.
// ----------------------------------------------------------------------------
module m3i_front #(
  parameter int WORD_BITS = 32
) (
  input  logic                                        clk_i,
  input  logic                                        rst_ni,
  input  logic                                        push_i,
  input  logic [m3i_pkg::NUM_EL-1:0][WORD_BITS-1:0]   a_i,
  output logic                                        full_o,
  output logic                                        out_push_o,
  input  logic                                        out_full_i,
  output logic [m3i_pkg::NUM_EL-1:0][2*WORD_BITS:0]   cof_o,
  output logic [3*WORD_BITS+2:0]                      det_o
);
  import m3i_pkg::*;

  localparam int W  = WORD_BITS;
  localparam int PW = 2 * W;
  localparam int CW = 2 * W + 1;
  localparam int DW = 3 * W + 3;

  logic        en;
  logic [5:0]  v_q;

  logic signed [W-1:0]  a_q  [NUM_EL];
  logic signed [PW-1:0] p_q  [2*NUM_EL];
  logic signed [W-1:0]  r1_q [3];
  logic signed [W-1:0]  r2_q [3];
  logic signed [CW-1:0] c2_q [NUM_EL];
  logic signed [CW-1:0] c3_q [NUM_EL];
  logic signed [CW-1:0] c4_q [NUM_EL];
  logic signed [CW-1:0] c5_q [NUM_EL];
  logic signed [2*W:0]  lo_q [3];
  logic signed [2*W:0]  hi_q [3];
  logic signed [DW-1:0] t_q  [3];
  logic signed [DW-1:0] det_q;

  // the whole front advances unless its last item cannot enter the queue
  assign en         = !(v_q[5] && out_full_i);
  assign full_o     = !en;
  assign out_push_o = v_q[5] && !out_full_i;

  // valid shift
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v_q <= '0;
    end else if (en) begin
      v_q <= {v_q[4:0], push_i};
    end
  end

  // element products and cofactors
  for (genvar k = 0; k < NUM_EL; k++) begin : g_cof
    always_ff @(posedge clk_i) begin
      if (en) begin
        a_q[k]      <= a_i[k];
        p_q[2*k]    <= PW'(a_q[COF_IDX[k][0]] * a_q[COF_IDX[k][1]]);
        p_q[2*k+1]  <= PW'(a_q[COF_IDX[k][2]] * a_q[COF_IDX[k][3]]);
        c2_q[k]     <= CW'(p_q[2*k]) - CW'(p_q[2*k+1]);
        c3_q[k]     <= c2_q[k];
        c4_q[k]     <= c3_q[k];
        c5_q[k]     <= c4_q[k];
      end
    end
  end

  // first-row terms: cofactor split into low and high halves per multiply
  for (genvar j = 0; j < 3; j++) begin : g_det
    always_ff @(posedge clk_i) begin
      if (en) begin
        r1_q[j] <= a_q[j];
        r2_q[j] <= r1_q[j];
        lo_q[j] <= (2*W+1)'(r2_q[j] * $signed({1'b0, c2_q[3*j][W-1:0]}));
        hi_q[j] <= (2*W+1)'(r2_q[j] * $signed(c2_q[3*j][CW-1:W]));
        t_q[j]  <= (DW'(hi_q[j]) <<< W) + DW'(lo_q[j]);
      end
    end
  end

  // determinant sum
  always_ff @(posedge clk_i) begin
    if (en) det_q <= t_q[0] + t_q[1] + t_q[2];
  end

  for (genvar k = 0; k < NUM_EL; k++) begin : g_out
    assign cof_o[k] = c5_q[k];
  end
  assign det_o = det_q;

endmodule

[rtl/m3i_back.sv]
// ----------------------------------------------------------------------------
// m3i_back
// Back pipeline: nine restoring dividers, one quotient bit per stage, then
// round half away from zero, saturate and restore the sign.
// ----------------------------------------------------------------------------
module m3i_back #(
  parameter int WORD_BITS = 32,
  parameter int FRAC_BITS = 16
) (
  input  logic                                        clk_i,
  input  logic                                        rst_ni,
  input  logic                                        in_empty_i,
  output logic                                        in_pop_o,
  input  logic [m3i_pkg::NUM_EL-1:0][2*WORD_BITS:0]   cof_i,
  input  logic [3*WORD_BITS+2:0]                      det_i,
  output logic                                        out_push_o,
  input  logic                                        out_full_i,
  output logic [m3i_pkg::NUM_EL-1:0][WORD_BITS-1:0]   r_o,
  output logic                                        singular_o,
  output logic                                        saturated_o
);
  import m3i_pkg::*;

  localparam int W  = WORD_BITS;
  localparam int CW = 2 * W + 1;
  localparam int DW = 3 * W + 3;
  localparam int NW = CW + 2 * FRAC_BITS;
  localparam int RW = ((NW > DW + W) ? NW : DW + W) + 1;
  localparam int NS = W + 3;

  logic                en;
  logic [NS-1:0]       vld_q;
  logic [NS-1:0]       sing_q;
  logic [DW-1:0]       dm_q  [NS];
  logic [RW-1:0]       rem_q [NS][NUM_EL];
  logic [W:0]          qa_q  [NS][NUM_EL];
  logic [NUM_EL-1:0]   neg_q [NS];
  logic [NUM_EL-1:0]   rb_q;
  logic [NUM_EL-1:0]   over;

  // all stages advance unless the finished item cannot enter the queue
  assign en         = !(vld_q[NS-1] && out_full_i);
  assign in_pop_o   = en && !in_empty_i;
  assign out_push_o = vld_q[NS-1] && !out_full_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (en) begin
      vld_q <= {vld_q[NS-2:0], in_pop_o};
    end
  end

  // magnitudes, result signs and zero determinant
  always_ff @(posedge clk_i) begin
    if (en) begin
      dm_q[0]   <= det_i[DW-1] ? DW'(-det_i) : det_i;
      sing_q[0] <= (det_i == '0);
      for (int k = 0; k < NUM_EL; k++) begin
        rem_q[0][k] <= RW'(cof_i[k][CW-1] ? CW'(-cof_i[k]) : cof_i[k]) << (2 * FRAC_BITS);
        qa_q[0][k]  <= '0;
        neg_q[0][k] <= cof_i[k][CW-1] ^ det_i[DW-1];
      end
    end
  end

  // one quotient bit per stage; the top bit flags a quotient too large
  for (genvar s = 1; s <= W + 1; s++) begin : g_div
    localparam int B = W + 1 - s;
    logic [RW:0] trial [NUM_EL];
    logic [W:0]  qn    [NUM_EL];

    always_comb begin
      for (int k = 0; k < NUM_EL; k++) begin
        trial[k] = {1'b0, rem_q[s-1][k]} - ((RW+1)'(dm_q[s-1]) << B);
        qn[k]    = qa_q[s-1][k];
        qn[k][B] = !trial[k][RW];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en) begin
        dm_q[s]   <= dm_q[s-1];
        sing_q[s] <= sing_q[s-1];
        neg_q[s]  <= neg_q[s-1];
        for (int k = 0; k < NUM_EL; k++) begin
          rem_q[s][k] <= trial[k][RW] ? rem_q[s-1][k] : trial[k][RW-1:0];
          qa_q[s][k]  <= qn[k];
        end
      end
    end
  end

  // rounding bit: twice the remainder against the divisor
  always_ff @(posedge clk_i) begin
    if (en) begin
      dm_q[NS-1]   <= dm_q[NS-2];
      sing_q[NS-1] <= sing_q[NS-2];
      neg_q[NS-1]  <= neg_q[NS-2];
      for (int k = 0; k < NUM_EL; k++) begin
        rem_q[NS-1][k] <= rem_q[NS-2][k];
        qa_q[NS-1][k]  <= qa_q[NS-2][k];
        rb_q[k]        <= ({rem_q[NS-2][k], 1'b0} >= (RW+1)'(dm_q[NS-2]));
      end
    end
  end

  // round, saturate, sign
  always_comb begin
    logic [W:0] q, lim, qs;
    for (int k = 0; k < NUM_EL; k++) begin
      q   = (W+1)'(qa_q[NS-1][k][W-1:0]) + (W+1)'(rb_q[k]);
      lim = neg_q[NS-1][k] ? ((W+1)'(1) << (W-1)) : (((W+1)'(1) << (W-1)) - 1'b1);
      over[k] = qa_q[NS-1][k][W] || (q > lim);
      qs  = over[k] ? lim : q;
      if (sing_q[NS-1])        r_o[k] = '0;
      else if (neg_q[NS-1][k]) r_o[k] = -qs[W-1:0];
      else                     r_o[k] = qs[W-1:0];
    end
  end

  assign singular_o  = sing_q[NS-1];
  assign saturated_o = !sing_q[NS-1] && (|over);

endmodule

[rtl/matrix3_inverse_unit.sv]
// ----------------------------------------------------------------------------
// matrix3_inverse_unit
// Inverse of a 3x3 signed fixed-point matrix by the adjugate.
// ----------------------------------------------------------------------------
// Usage:
//   Input side is a queue write port: a matrix a00..a22 is taken on a
//   rising edge with push high and full low. Result side is a queue read
//   port: while empty is low, r00..r22, singular and saturated show the
//   oldest result, which is removed on an edge with pop high.
//   Each inverse element is cofactor / determinant in the input format,
//   rounded half away from zero and saturated (saturated is set then).
//   A zero determinant gives zero elements with singular set.
// Timing:
//   One matrix per cycle sustained while pop keeps pace. The transfer
//   edge loads the first of a 6-stage cofactor and determinant front;
//   each item then passes the middle queue, WORD_BITS + 3 back stages
//   (magnitudes, divider stages of one quotient bit each, rounding) and
//   the result queue.
// Reset and stall:
//   Reset empties both queues and the pipelines. When pop is held low the
//   result queue fills, then the divider stalls, then the middle queue
//   fills and the front raises full; nothing is dropped.
// ----------------------------------------------------------------------------
module matrix3_inverse_unit #(
  parameter int WORD_BITS = 32,
  parameter int FRAC_BITS = 16
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 push,
  output logic                 full,
  input  logic [WORD_BITS-1:0] a00_i,
  input  logic [WORD_BITS-1:0] a01_i,
  input  logic [WORD_BITS-1:0] a02_i,
  input  logic [WORD_BITS-1:0] a10_i,
  input  logic [WORD_BITS-1:0] a11_i,
  input  logic [WORD_BITS-1:0] a12_i,
  input  logic [WORD_BITS-1:0] a20_i,
  input  logic [WORD_BITS-1:0] a21_i,
  input  logic [WORD_BITS-1:0] a22_i,
  output logic                 empty,
  input  logic                 pop,
  output logic [WORD_BITS-1:0] r00_o,
  output logic [WORD_BITS-1:0] r01_o,
  output logic [WORD_BITS-1:0] r02_o,
  output logic [WORD_BITS-1:0] r10_o,
  output logic [WORD_BITS-1:0] r11_o,
  output logic [WORD_BITS-1:0] r12_o,
  output logic [WORD_BITS-1:0] r20_o,
  output logic [WORD_BITS-1:0] r21_o,
  output logic [WORD_BITS-1:0] r22_o,
  output logic                 singular_o,
  output logic                 saturated_o
);
  import m3i_pkg::*;

  localparam int W      = WORD_BITS;
  localparam int CW     = 2 * W + 1;
  localparam int DW     = 3 * W + 3;
  localparam int MID_W  = NUM_EL * CW + DW;
  localparam int OUT_W  = NUM_EL * W + 2;
  localparam int QDEPTH = 4;

  logic [NUM_EL-1:0][W-1:0]  a;
  logic [NUM_EL-1:0][CW-1:0] f_cof, b_cof;
  logic [DW-1:0]             f_det, b_det;
  logic                      mid_push, mid_full, mid_pop, mid_empty;
  logic                      out_push, out_full;
  logic [NUM_EL-1:0][W-1:0]  b_r, q_r;
  logic                      b_sing, b_sat, q_sing, q_sat;

  assign a = {a22_i, a21_i, a20_i, a12_i, a11_i, a10_i, a02_i, a01_i, a00_i};

  // cofactors and determinant
  m3i_front #(.WORD_BITS(W)) u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .push_i     (push && !full),
    .a_i        (a),
    .full_o     (full),
    .out_push_o (mid_push),
    .out_full_i (mid_full),
    .cof_o      (f_cof),
    .det_o      (f_det)
  );

  // queue between front and divider
  m3i_fifo #(.DATA_BITS(MID_W), .DEPTH(QDEPTH)) u_mid_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (mid_push),
    .data_i  ({f_cof, f_det}),
    .full_o  (mid_full),
    .pop_i   (mid_pop),
    .data_o  ({b_cof, b_det}),
    .empty_o (mid_empty)
  );

  // division, rounding and saturation
  m3i_back #(.WORD_BITS(W), .FRAC_BITS(FRAC_BITS)) u_back (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_empty_i  (mid_empty),
    .in_pop_o    (mid_pop),
    .cof_i       (b_cof),
    .det_i       (b_det),
    .out_push_o  (out_push),
    .out_full_i  (out_full),
    .r_o         (b_r),
    .singular_o  (b_sing),
    .saturated_o (b_sat)
  );

  // result queue
  m3i_fifo #(.DATA_BITS(OUT_W), .DEPTH(QDEPTH)) u_out_q (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (out_push),
    .data_i  ({b_r, b_sing, b_sat}),
    .full_o  (out_full),
    .pop_i   (pop),
    .data_o  ({q_r, q_sing, q_sat}),
    .empty_o (empty)
  );

  assign r00_o       = q_r[0];
  assign r01_o       = q_r[1];
  assign r02_o       = q_r[2];
  assign r10_o       = q_r[3];
  assign r11_o       = q_r[4];
  assign r12_o       = q_r[5];
  assign r20_o       = q_r[6];
  assign r21_o       = q_r[7];
  assign r22_o       = q_r[8];
  assign singular_o  = q_sing;
  assign saturated_o = q_sat;

endmodule

[dv/matrix3_inverse_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// matrix3_inverse_checker
// Watches both queue ports of the 3x3 inverse unit, computes the expected
// inverse of every matrix taken in and compares each result popped out.
// ----------------------------------------------------------------------------
module matrix3_inverse_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        push_i,
  input  logic        full_i,
  input  logic [31:0] mat_i [m3i_pkg::NUM_EL],
  input  logic        pop_i,
  input  logic        empty_i,
  input  logic [31:0] inv_i [m3i_pkg::NUM_EL],
  input  logic        singular_i,
  input  logic        saturated_i,
  output int          errors_o,
  output int          pending_o,
  output int          checked_o,
  output int          singular_seen_o,
  output int          saturated_seen_o,
  output logic        transfer_o
);
  import m3i_pkg::*;

  localparam int WB = 32;
  localparam int FB = 16;

  typedef struct {
    logic [WB-1:0] el [NUM_EL];
    logic          singular;
    logic          saturated;
  } inverse_t;

  inverse_t inverse_q[$];

  // exact adjugate inverse, rounded half away from zero, then clipped
  function automatic inverse_t compute_inverse(logic [WB-1:0] m [NUM_EL]);
    logic signed [127:0] x [NUM_EL];
    logic signed [127:0] cof [NUM_EL];
    logic signed [127:0] det;
    logic [127:0]        dmag, nmag, quo, rem, lim;
    logic                neg;
    inverse_t            res;
    for (int i = 0; i < NUM_EL; i++) x[i] = {{(128-WB){m[i][WB-1]}}, m[i]};
    for (int k = 0; k < NUM_EL; k++) begin
      cof[k] = x[COF_IDX[k][0]] * x[COF_IDX[k][1]] - x[COF_IDX[k][2]] * x[COF_IDX[k][3]];
    end
    det = x[0] * cof[0] + x[1] * cof[3] + x[2] * cof[6];
    res.singular  = (det == 0);
    res.saturated = 1'b0;
    if (det == 0) begin
      for (int i = 0; i < NUM_EL; i++) res.el[i] = '0;
      return res;
    end
    dmag = det[127] ? -det : det;
    for (int i = 0; i < NUM_EL; i++) begin
      neg  = cof[i][127] ^ det[127];
      nmag = (cof[i][127] ? -cof[i] : cof[i]) << (2 * FB);
      quo  = nmag / dmag;
      rem  = nmag % dmag;
      if ((rem << 1) >= dmag) quo = quo + 1;
      lim = neg ? (128'd1 << (WB - 1)) : ((128'd1 << (WB - 1)) - 1);
      if (quo > lim) begin
        quo = lim;
        res.saturated = 1'b1;
      end
      res.el[i] = neg ? WB'(-quo) : WB'(quo);
    end
    return res;
  endfunction

  assign pending_o  = inverse_q.size();
  assign transfer_o = (push_i && !full_i) || (pop_i && !empty_i);

  // predict on input transfer, compare on output transfer
  always @(posedge clk_i or negedge rst_ni) begin
    inverse_t exp_r;
    logic     bad;
    if (!rst_ni) begin
      inverse_q.delete();
      errors_o <= 0;
      checked_o <= 0;
      singular_seen_o <= 0;
      saturated_seen_o <= 0;
    end else begin
      if (push_i && !full_i) inverse_q.push_back(compute_inverse(mat_i));
      if (pop_i && !empty_i) begin
        if (inverse_q.size() == 0) begin
          if (errors_o < 10) $display("ERROR: result popped with none expected");
          errors_o <= errors_o + 1;
        end else begin
          exp_r = inverse_q.pop_front();
          bad = (singular_i !== exp_r.singular) || (saturated_i !== exp_r.saturated);
          for (int i = 0; i < NUM_EL; i++) if (inv_i[i] !== exp_r.el[i]) bad = 1'b1;
          if (bad) begin
            if (errors_o < 10) begin
              $display("ERROR: result %0d mismatch (singular %b/%b, saturated %b/%b)",
                       checked_o, singular_i, exp_r.singular, saturated_i, exp_r.saturated);
              for (int i = 0; i < NUM_EL; i++)
                $display("  r%0d%0d got %h expected %h", i / 3, i % 3, inv_i[i],
                         exp_r.el[i]);
            end
            errors_o <= errors_o + 1;
          end
          checked_o <= checked_o + 1;
          if (exp_r.singular) singular_seen_o <= singular_seen_o + 1;
          if (exp_r.saturated) saturated_seen_o <= saturated_seen_o + 1;
        end
      end
    end
  end

endmodule

[dv/testbench.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives matrices into the 3x3 inverse unit in bursts with random pop
// stalls: directed corner matrices first, then a random mix.
// ----------------------------------------------------------------------------
module testbench;
  import m3i_pkg::*;

  localparam int ONE       = 32'h0001_0000;
  localparam int N_RANDOM  = 1080;
  localparam int IDLE_LIM  = 5000;
  localparam int DRAIN_CYC = 60;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        push = 1'b0;
  logic        pop = 1'b0;
  logic        full, empty, singular, saturated, transfer;
  logic [31:0] mat [NUM_EL];
  logic [31:0] inv [NUM_EL];
  int          errors, pending, checked, n_singular, n_saturated;
  int          idle_cnt = 0;
  int          pop_cyc = 0;
  int          stall_left = 0;

  initial for (int i = 0; i < NUM_EL; i++) mat[i] = '0;

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  matrix3_inverse_unit dut (
    .clk_i, .rst_ni, .push, .full,
    .a00_i(mat[0]), .a01_i(mat[1]), .a02_i(mat[2]),
    .a10_i(mat[3]), .a11_i(mat[4]), .a12_i(mat[5]),
    .a20_i(mat[6]), .a21_i(mat[7]), .a22_i(mat[8]),
    .empty, .pop,
    .r00_o(inv[0]), .r01_o(inv[1]), .r02_o(inv[2]),
    .r10_o(inv[3]), .r11_o(inv[4]), .r12_o(inv[5]),
    .r20_o(inv[6]), .r21_o(inv[7]), .r22_o(inv[8]),
    .singular_o(singular), .saturated_o(saturated)
  );

  matrix3_inverse_checker u_checker (
    .clk_i, .rst_ni, .push_i(push), .full_i(full), .mat_i(mat),
    .pop_i(pop), .empty_i(empty), .inv_i(inv), .singular_i(singular),
    .saturated_i(saturated), .errors_o(errors), .pending_o(pending),
    .checked_o(checked), .singular_seen_o(n_singular),
    .saturated_seen_o(n_saturated), .transfer_o(transfer)
  );

  // pop pattern: free flow, coin flips and long stalls in turn
  always @(posedge clk_i) begin
    pop_cyc <= pop_cyc + 1;
    case ((pop_cyc / 300) % 3)
      0: pop <= 1'b1;
      1: pop <= 1'($urandom_range(1, 0));
      default: begin
        if (stall_left > 0) begin
          stall_left <= stall_left - 1;
          pop <= 1'b0;
        end else if ($urandom_range(7, 0) == 0) begin
          stall_left <= $urandom_range(40, 5);
          pop <= 1'b0;
        end else begin
          pop <= 1'b1;
        end
      end
    endcase
  end

  // watchdog on cycles without any transfer
  always @(posedge clk_i) begin
    idle_cnt <= transfer ? 0 : idle_cnt + 1;
    if (idle_cnt > IDLE_LIM) begin
      $display("timeout: no transfer for %0d cycles", IDLE_LIM);
      $display("Verification failed");
      $finish;
    end
  end

  // present one matrix and hold it until the transfer
  task automatic send_matrix(input logic [31:0] m [NUM_EL]);
    logic taken;
    push <= 1'b1;
    for (int i = 0; i < NUM_EL; i++) mat[i] <= m[i];
    do begin
      @(negedge clk_i);
      taken = !full;
      @(posedge clk_i);
    end while (!taken);
  endtask

  // burst gaps: sometimes drop push for a while
  task automatic maybe_gap();
    if ($urandom_range(9, 0) == 0) begin
      push <= 1'b0;
      repeat ($urandom_range(12, 1)) @(posedge clk_i);
    end
  endtask

  function automatic logic [31:0] near_one();
    logic [31:0] v;
    v = $urandom_range(4 * ONE, ONE / 2);
    return $urandom_range(1, 0) ? -v : v;
  endfunction

  function automatic logic [31:0] small_val(int span);
    return $signed($urandom_range(2 * span, 0)) - span;
  endfunction

  task automatic build_random(output logic [31:0] m [NUM_EL]);
    int kind;
    int r;
    kind = $urandom_range(99, 0);
    for (int i = 0; i < NUM_EL; i++) m[i] = $urandom();
    if (kind < 40) begin
      // well conditioned: strong diagonal, moderate rest
      for (int i = 0; i < NUM_EL; i++)
        m[i] = (i % 4 == 0) ? near_one() : small_val(ONE);
    end else if (kind < 55) begin
      // singular: repeated row, zero column or negated row
      for (int i = 0; i < NUM_EL; i++) m[i] = small_val(8 * ONE);
      r = $urandom_range(2, 0);
      if (r == 0) for (int j = 0; j < 3; j++) m[6 + j] = m[3 + j];
      else if (r == 1) for (int j = 0; j < 3; j++) m[3 * j + 1] = '0;
      else for (int j = 0; j < 3; j++) m[j] = -m[3 + j];
    end else if (kind < 70) begin
      for (int i = 0; i < NUM_EL; i++) m[i] = small_val(1 << 20);
    end else if (kind < 85) begin
      // tiny elements push the inverse out of range
      for (int i = 0; i < NUM_EL; i++) m[i] = small_val(64);
    end
  endtask

  task automatic directed();
    logic [31:0] m [NUM_EL];
    logic [31:0] fill [6];
    fill = '{32'h8000_0000, 32'h7fff_ffff, 32'hffff_ffff, 32'h0000_0001,
             32'h0000_0000, 32'hffff_0000};
    // constant matrices: all singular
    foreach (fill[f]) begin
      for (int i = 0; i < NUM_EL; i++) m[i] = fill[f];
      send_matrix(m);
    end
    // identity, scaled identities and extreme diagonals
    foreach (fill[f]) begin
      for (int i = 0; i < NUM_EL; i++) m[i] = (i % 4 == 0) ? fill[f] : 32'h0;
      send_matrix(m);
    end
    for (int i = 0; i < NUM_EL; i++) m[i] = (i % 4 == 0) ? ONE : 32'h0;
    send_matrix(m);
    // halfway quotients: diag 2.0 with a01 = +-2, +-6 lsb gives r01 = -+0.5, -+1.5 lsb
    for (int b = 0; b < 4; b++) begin
      for (int i = 0; i < NUM_EL; i++) m[i] = (i % 4 == 0) ? 2 * ONE : 32'h0;
      m[1] = (b < 2 ? 2 : 6) * (b % 2 ? -1 : 1);
      send_matrix(m);
    end
    // mixed signs at full scale
    for (int i = 0; i < NUM_EL; i++)
      m[i] = (i % 2) ? 32'h8000_0000 : 32'h7fff_ffff;
    send_matrix(m);
    for (int i = 0; i < NUM_EL; i++) m[i] = (i % 4 == 0) ? 32'h8000_0000 : 32'h0000_0001;
    send_matrix(m);
    // tiny diagonal: saturates both ways
    for (int i = 0; i < NUM_EL; i++) m[i] = 32'h0;
    m[0] = 1; m[4] = -1; m[8] = 2;
    send_matrix(m);
  endtask

  initial begin
    logic [31:0] m [NUM_EL];
    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    directed();
    for (int n = 0; n < N_RANDOM; n++) begin
      maybe_gap();
      build_random(m);
      send_matrix(m);
    end
    push <= 1'b0;
    while (pending != 0) @(posedge clk_i);
    repeat (DRAIN_CYC) @(posedge clk_i);
    $display("checked %0d inverses: %0d singular, %0d saturated",
             checked, n_singular, n_saturated);
    $display("mismatches: %0d", errors);
    if (errors == 0 && pending == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule

[sim.f]
rtl/m3i_pkg.sv
rtl/m3i_fifo.sv
rtl/m3i_front.sv
rtl/m3i_back.sv
rtl/matrix3_inverse_unit.sv
dv/matrix3_inverse_checker.sv
dv/testbench.sv
